// ===== design/htr_pkg.sv =====
// htr_pkg: shared types and constants for the HTML tag recognizer.
// No dependencies; used by the interfaces, the matcher, the register file and the top level.
`timescale 1ns / 1ps

package htr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned ConsumedW = 16;
  localparam int unsigned NameRegs  = 4;
  localparam int unsigned NameW     = 64;
  localparam int unsigned CountW    = 3;

  localparam logic [VerdictW-1:0] VMore   = 2'd0;
  localparam logic [VerdictW-1:0] VAccept = 2'd1;
  localparam logic [VerdictW-1:0] VReject = 2'd2;
  localparam logic [VerdictW-1:0] VIdle   = 2'd3;

  localparam logic [ByteW-1:0] CharLt = 8'h3C;

  typedef struct packed {
    logic [CountW-1:0]                forbidden_count;
    logic [NameRegs-1:0][NameW-1:0]   forbidden_names;
  } cfg_t;

  typedef struct packed {
    logic [VerdictW-1:0]  verdict;
    logic                 closing;
    logic [ConsumedW-1:0] consumed;
  } res_t;

endpackage

// ===== design/htr_if.sv =====
// htr_if: valid/ready channel interfaces for input bytes and per-byte results.
// Depends on htr_pkg for field widths.
`timescale 1ns / 1ps

interface htr_in_if;
  logic                      valid;
  logic                      ready;
  logic [htr_pkg::ByteW-1:0] text_byte;
  logic                      begin_req;

  modport source (output valid, output text_byte, output begin_req, input ready);
  modport sink   (input valid, input text_byte, input begin_req, output ready);
endinterface

interface htr_out_if;
  logic                          valid;
  logic                          ready;
  logic [htr_pkg::VerdictW-1:0]  verdict;
  logic                          closing;
  logic [htr_pkg::ConsumedW-1:0] consumed;

  modport source (output valid, output verdict, output closing, output consumed, input ready);
  modport sink   (input valid, input verdict, input closing, input consumed, output ready);
endinterface

// ===== design/htr_cfg_regs.sv =====
// htr_cfg_regs: APB register file holding the forbidden tag names and their count.
// Depends on htr_pkg (cfg_t).
`timescale 1ns / 1ps

module htr_cfg_regs #(
  parameter int FORBIDDEN_SLOTS = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [5:0]                  paddr,
  input  logic [htr_pkg::NameW-1:0]   pwdata,
  output logic [htr_pkg::NameW-1:0]   prdata,
  output logic                        pready,
  output htr_pkg::cfg_t               cfg_o
);

  typedef enum logic [2:0] {
    RegCount = 3'd0,
    RegNameA = 3'd1,
    RegNameB = 3'd2,
    RegNameC = 3'd3,
    RegNameD = 3'd4
  } reg_idx_e;

  htr_pkg::cfg_t cfg_q;
  reg_idx_e      idx;
  logic [1:0]    slot;
  logic          wr_en;

  assign idx    = reg_idx_e'(paddr[5:3]);
  assign slot   = 2'(paddr[5:3] - 3'd1);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx) inside
        RegCount: cfg_q.forbidden_count <= pwdata[htr_pkg::CountW-1:0];
        RegNameA, RegNameB, RegNameC, RegNameD: begin
          if (32'(slot) < FORBIDDEN_SLOTS) cfg_q.forbidden_names[slot] <= pwdata;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx) inside
      RegCount: prdata = htr_pkg::NameW'(cfg_q.forbidden_count);
      RegNameA, RegNameB, RegNameC, RegNameD: prdata = cfg_q.forbidden_names[slot];
      default: prdata = '0;
    endcase
  end

endmodule

// ===== design/htr_matcher.sv =====
// htr_matcher: tag grammar state machine, name capture and forbidden-name compare.
// Depends on htr_pkg (cfg_t, res_t, verdict codes). One byte per fire_i.
`timescale 1ns / 1ps

module htr_matcher #(
  parameter int FORBIDDEN_SLOTS = 4,
  parameter int NAME_BYTES      = 8,
  parameter int COUNT_BITS      = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      fire_i,
  input  logic [htr_pkg::ByteW-1:0] text_byte_i,
  input  logic                      begin_req_i,
  input  htr_pkg::cfg_t             cfg_i,
  output htr_pkg::res_t             result_o
);

  localparam int NcW = $clog2(NAME_BYTES + 2);
  localparam int StoreBytes = htr_pkg::NameW / 8;

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_LT        = 4'd1;
  localparam logic [3:0] PH_SLASH     = 4'd2;
  localparam logic [3:0] PH_NAME      = 4'd3;
  localparam logic [3:0] PH_RUN       = 4'd4;
  localparam logic [3:0] PH_AN_RUN    = 4'd5;
  localparam logic [3:0] PH_EQ_RUN    = 4'd6;
  localparam logic [3:0] PH_ATTR      = 4'd7;
  localparam logic [3:0] PH_UNQ       = 4'd8;
  localparam logic [3:0] PH_SQ        = 4'd9;
  localparam logic [3:0] PH_DQ        = 4'd10;
  localparam logic [3:0] PH_END_SLASH = 4'd11;

  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChTick  = 8'h60;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef struct packed {
    logic [1:0] v;
    logic       tk;
    logic [3:0] ph;
    logic       nl;
  } step_t;

  function automatic logic is_upper(logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return is_upper(c) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return is_upper(c) ? c + 8'd32 : c;
  endfunction

  function automatic logic attr_start(logic [7:0] c);
    return is_letter(c) || c == ChUnder || c == ChColon;
  endfunction

  function automatic logic attr_more(logic [7:0] c);
    return is_letter(c) || c == ChUnder || c == ChDot || c == ChColon || c == ChDash;
  endfunction

  function automatic logic unquoted_ok(logic [7:0] c);
    return c != 8'h00 && c != ChSp && c != ChTab && c != ChLf && c != ChSq && c != ChDq &&
           c != ChEq && c != htr_pkg::CharLt && c != ChGt && c != ChTick;
  endfunction

  function automatic logic [htr_pkg::NameW-1:0] fold_word(logic [htr_pkg::NameW-1:0] w);
    logic [htr_pkg::NameW-1:0] r;
    r = '0;
    for (int k = 0; k < StoreBytes; k++) r[8*k +: 8] = to_lower(w[8*k +: 8]);
    return r;
  endfunction

  // whitespace run byte, or the byte that ends the run
  function automatic step_t run_step(logic [7:0] c, logic [3:0] rp, logic nl, logic cls);
    step_t s;
    s.v  = htr_pkg::VReject;
    s.tk = 1'b0;
    s.ph = rp;
    s.nl = nl;
    if (c == ChSp || c == ChTab) begin
      s.v = htr_pkg::VMore; s.tk = 1'b1;
    end else if (c == ChLf) begin
      if (!nl) begin
        s.nl = 1'b1; s.v = htr_pkg::VMore; s.tk = 1'b1;
      end
    end else if (rp == PH_EQ_RUN) begin
      if (c == ChSq) begin
        s.ph = PH_SQ; s.v = htr_pkg::VMore; s.tk = 1'b1;
      end else if (c == ChDq) begin
        s.ph = PH_DQ; s.v = htr_pkg::VMore; s.tk = 1'b1;
      end else if (unquoted_ok(c)) begin
        s.ph = PH_UNQ; s.v = htr_pkg::VMore; s.tk = 1'b1;
      end
    end else if (rp == PH_AN_RUN && c == ChEq) begin
      s.ph = PH_EQ_RUN; s.nl = 1'b0; s.v = htr_pkg::VMore; s.tk = 1'b1;
    end else if (attr_start(c)) begin
      s.ph = PH_ATTR; s.v = htr_pkg::VMore; s.tk = 1'b1;
    end else if (c == ChSlash && !cls) begin
      s.ph = PH_END_SLASH; s.v = htr_pkg::VMore; s.tk = 1'b1;
    end else if (c == ChGt) begin
      s.v = htr_pkg::VAccept; s.tk = 1'b1;
    end
    return s;
  endfunction

  logic [3:0]                ph_q, ph_d;
  logic [htr_pkg::NameW-1:0] ns_q, ns_d;
  logic [NcW-1:0]            nc_q, nc_d;
  logic                      nl_q, nl_d;
  logic                      cl_q, cl_d;
  logic [COUNT_BITS-1:0]     bc_q, bc_d;

  logic [7:0]  c;
  logic [1:0]  v;
  logic        tk;
  logic        add;
  logic        hit;
  logic [3:0]  n_used;
  step_t       st;
  logic [32:0] bc_ext;

  assign c = text_byte_i;

  always_comb begin
    n_used = (32'(cfg_i.forbidden_count) > FORBIDDEN_SLOTS) ?
             4'(FORBIDDEN_SLOTS) : 4'(cfg_i.forbidden_count);
    hit = 1'b0;
    for (int i = 0; i < htr_pkg::NameRegs; i++) begin
      if (4'(i) < n_used && fold_word(cfg_i.forbidden_names[i]) == ns_q) hit = 1'b1;
    end
    if (32'(nc_q) > NAME_BYTES) hit = 1'b0;
  end

  always_comb begin
    ph_d = ph_q;
    ns_d = ns_q;
    nc_d = nc_q;
    nl_d = nl_q;
    cl_d = cl_q;
    bc_d = bc_q;
    v    = htr_pkg::VIdle;
    tk   = 1'b0;
    add  = 1'b0;
    st   = '0;
    if (begin_req_i) begin
      cl_d = 1'b0;
      bc_d = '0;
      ns_d = '0;
      nc_d = '0;
      nl_d = 1'b0;
      if (c == htr_pkg::CharLt) begin
        ph_d = PH_LT; v = htr_pkg::VMore; tk = 1'b1;
      end else begin
        v = htr_pkg::VReject;
      end
    end else begin
      unique case (ph_q) inside
        PH_LT: begin
          if (c == ChSlash) begin
            cl_d = 1'b1; ph_d = PH_SLASH; v = htr_pkg::VMore; tk = 1'b1;
          end else if (is_letter(c)) begin
            add = 1'b1; ph_d = PH_NAME; v = htr_pkg::VMore; tk = 1'b1;
          end else begin
            v = htr_pkg::VReject;
          end
        end
        PH_SLASH: begin
          if (is_letter(c)) begin
            add = 1'b1; ph_d = PH_NAME; v = htr_pkg::VMore; tk = 1'b1;
          end else begin
            v = htr_pkg::VReject;
          end
        end
        PH_NAME: begin
          if (is_letter(c) || is_digit(c) || c == ChDash) begin
            add = 1'b1; v = htr_pkg::VMore; tk = 1'b1;
          end else if (hit) begin
            v = htr_pkg::VReject;
          end else begin
            st = run_step(c, PH_RUN, 1'b0, cl_q);
            ph_d = st.ph; nl_d = st.nl; v = st.v; tk = st.tk;
          end
        end
        PH_ATTR: begin
          if (attr_more(c)) begin
            v = htr_pkg::VMore; tk = 1'b1;
          end else begin
            st = run_step(c, PH_AN_RUN, 1'b0, cl_q);
            ph_d = st.ph; nl_d = st.nl; v = st.v; tk = st.tk;
          end
        end
        PH_UNQ: begin
          if (unquoted_ok(c)) begin
            v = htr_pkg::VMore; tk = 1'b1;
          end else begin
            st = run_step(c, PH_RUN, 1'b0, cl_q);
            ph_d = st.ph; nl_d = st.nl; v = st.v; tk = st.tk;
          end
        end
        PH_SQ, PH_DQ: begin
          if (c == 8'h00) begin
            v = htr_pkg::VReject;
          end else begin
            if ((ph_q == PH_SQ && c == ChSq) || (ph_q == PH_DQ && c == ChDq)) begin
              ph_d = PH_RUN; nl_d = 1'b0;
            end
            v = htr_pkg::VMore; tk = 1'b1;
          end
        end
        PH_RUN, PH_AN_RUN, PH_EQ_RUN: begin
          st = run_step(c, ph_q, nl_q, cl_q);
          ph_d = st.ph; nl_d = st.nl; v = st.v; tk = st.tk;
        end
        PH_END_SLASH: begin
          if (c == ChGt) begin
            v = htr_pkg::VAccept; tk = 1'b1;
          end else begin
            v = htr_pkg::VReject;
          end
        end
        default: v = htr_pkg::VIdle;
      endcase
    end

    if (add) begin
      if (32'(nc_q) < NAME_BYTES) begin
        for (int k = 0; k < StoreBytes; k++) begin
          if (nc_q == NcW'(k)) ns_d[8*k +: 8] = to_lower(c);
        end
        nc_d = nc_q + NcW'(1);
      end else begin
        nc_d = NcW'(NAME_BYTES + 1);
      end
    end
    if (tk && bc_d != CountMax) bc_d = bc_d + COUNT_BITS'(1);
    if (v == htr_pkg::VAccept || v == htr_pkg::VReject) ph_d = PH_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
      ns_q <= '0;
      nc_q <= '0;
      nl_q <= 1'b0;
      cl_q <= 1'b0;
      bc_q <= '0;
    end else if (fire_i) begin
      ph_q <= ph_d;
      ns_q <= ns_d;
      nc_q <= nc_d;
      nl_q <= nl_d;
      cl_q <= cl_d;
      bc_q <= bc_d;
    end
  end

  assign bc_ext = 33'(bc_d);
  assign result_o.verdict  = v;
  assign result_o.closing  = cl_d;
  assign result_o.consumed = (bc_ext > 33'h0FFFF) ? 16'hFFFF : bc_ext[15:0];

  ap_decided_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (v == htr_pkg::VAccept || v == htr_pkg::VReject)) |=> ph_q == PH_IDLE)
    else $error("phase not idle after decision");

  ap_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !begin_req_i && ph_q == PH_IDLE) |=> ph_q == PH_IDLE && $stable(bc_q))
    else $error("idle phase moved without begin");

  ap_name_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(nc_q) <= NAME_BYTES + 1)
    else $error("name count out of range");

endmodule

// ===== design/html_tag_recognizer.sv =====
// html_tag_recognizer: top level with input register, matcher, result register and APB regs.
// Depends on htr_pkg, htr_if, htr_cfg_regs and htr_matcher.
// Result path: input register, then result register, loaded once no unaccepted result waits.
// Throughput: 1 byte per cycle; input ready drops only while a result waits and the input
// register is full.
// Reset: asynchronous active low; phase idle, counters and config zero, no result pending.
`timescale 1ns / 1ps

module html_tag_recognizer #(
  parameter int FORBIDDEN_SLOTS = 4,
  parameter int NAME_BYTES      = 8,
  parameter int COUNT_BITS      = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  htr_in_if.sink                    in_i,
  htr_out_if.source                 out_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [5:0]                paddr,
  input  logic [htr_pkg::NameW-1:0] pwdata,
  output logic [htr_pkg::NameW-1:0] prdata,
  output logic                      pready
);

  htr_pkg::cfg_t cfg;
  htr_pkg::res_t res_d, res_q;

  logic                      in_vld_q;
  logic [htr_pkg::ByteW-1:0] in_byte_q;
  logic                      in_beg_q;
  logic                      out_vld_q;
  logic                      adv;
  logic                      fire;
  logic                      in_take;

  assign adv      = !out_vld_q || out_o.ready;
  assign fire     = in_vld_q && adv;
  assign in_i.ready = !in_vld_q || adv;
  assign in_take  = in_i.valid && in_i.ready;

  htr_cfg_regs #(
    .FORBIDDEN_SLOTS(FORBIDDEN_SLOTS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  htr_matcher #(
    .FORBIDDEN_SLOTS(FORBIDDEN_SLOTS),
    .NAME_BYTES     (NAME_BYTES),
    .COUNT_BITS     (COUNT_BITS)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .text_byte_i(in_byte_q),
    .begin_req_i(in_beg_q),
    .cfg_i      (cfg),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (fire) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= in_i.text_byte;
      in_beg_q  <= in_i.begin_req;
    end
    if (fire) res_q <= res_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.verdict  = res_q.verdict;
  assign out_o.closing  = res_q.closing;
  assign out_o.consumed = res_q.consumed;

  ap_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("processed transaction produced no result");

  ap_in_reg_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> in_vld_q && $stable(in_byte_q) && $stable(in_beg_q))
    else $error("input register lost a stalled transaction");

  ap_bad_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_beg_q && in_byte_q != htr_pkg::CharLt) |=>
      (res_q.verdict == htr_pkg::VReject && res_q.consumed == '0 && !res_q.closing))
    else $error("begin without '<' not rejected");

  ap_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> out_vld_q && $stable(res_q))
    else $error("stalled result changed");

endmodule
